@@ sv/restriction_site_scanner_top_assert.svh @@
// Assertion macros for the restriction site scanner.
// Both macros expect clk_i in the scope where they are used; RSS_ASSERT also needs rst_ni.
`ifndef RESTRICTION_SITE_SCANNER_TOP_ASSERT_SVH
`define RESTRICTION_SITE_SCANNER_TOP_ASSERT_SVH

// Checked only outside reset.
`define RSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked during reset as well.
`define RSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/rss_pkg.sv @@
`default_nettype none

package rss_pkg;

  // Sizing
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned PosWidth   = 32;
  localparam int unsigned PatNibbles = 16;
  localparam int unsigned PatWidth   = 4 * PatNibbles;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned CfgIdxW    = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBases  = 2'd0,
    CfgPatternLength = 2'd1,
    CfgNickOffset    = 2'd2,
    CfgPalindrome    = 2'd3
  } cfg_idx_e;

  typedef logic [3:0] base_t;

  // Pattern set-up, pre-aligned to the window slots
  typedef struct packed {
    logic [LenW-1:0]              len;
    logic [LenW-1:0]              nick;
    logic                         palindrome;
    logic [MaxPattern-1:0]        slot_en;
    base_t [MaxPattern-1:0]       plus_pat;
    base_t [MaxPattern-1:0]       minus_pat;
  } scan_cfg_t;

  // Window contents after the latest base
  typedef struct packed {
    base_t [MaxPattern-1:0]       bases;
    logic [LenW-1:0]              fill;
    logic [CountWidth-1:0]        total;
  } win_state_t;

  // One accepted input transfer
  typedef struct packed {
    logic                         accept;
    base_t                        base;
    logic                         fragment_start;
  } in_item_t;

  // Complement of an ambiguity mask: bit order reversed
  function automatic base_t comp_mask(base_t m);
    comp_mask = {m[0], m[1], m[2], m[3]};
  endfunction

endpackage

`default_nettype wire

@@ sv/rss_cfg.sv @@
`default_nettype none

module rss_cfg import rss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire logic [CfgIdxW-1:0] idx_i,
  input  wire logic [PatWidth-1:0] data_i,
  output scan_cfg_t               cfg_o
);

  logic [PatNibbles-1:0][3:0] pattern_q;
  logic [4:0]                 length_q;
  logic [4:0]                 nick_q;
  logic                       pal_q;

  scan_cfg_t cfg_d, cfg_q;
  logic [LenW-1:0] len_eff;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= 5'd1;
      nick_q    <= '0;
      pal_q     <= 1'b0;
    end else if (wr_i) begin
      case (cfg_idx_e'(idx_i))
        CfgPatternBases:  pattern_q <= data_i;
        CfgPatternLength: length_q  <= data_i[4:0];
        CfgNickOffset:    nick_q    <= data_i[4:0];
        CfgPalindrome:    pal_q     <= data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp length and nick, align pattern to window slots (slot 0 = newest base)
  always_comb begin
    if (length_q == 5'd0) begin
      len_eff = LenW'(1);
    end else if (32'(length_q) > MaxPattern) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = LenW'(length_q);
    end

    cfg_d            = '0;
    cfg_d.len        = len_eff;
    cfg_d.palindrome = pal_q;
    if (32'(nick_q) > 32'(len_eff)) begin
      cfg_d.nick = len_eff;
    end else begin
      cfg_d.nick = LenW'(nick_q);
    end

    for (int j = 0; j < MaxPattern; j++) begin
      cfg_d.slot_en[j]   = (32'(j) < 32'(len_eff));
      // plus strand: newest slot meets the last pattern base
      cfg_d.plus_pat[j]  = pattern_q[4'(32'(len_eff) - 32'd1 - 32'(j))];
      cfg_d.minus_pat[j] = comp_mask(pattern_q[4'(j)]);
    end
  end

  // Derived set-up is registered behind the register file
  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/rss_window.sv @@
`default_nettype none

module rss_window import rss_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire in_item_t item_i,
  output win_state_t win_o
);

  base_t [MaxPattern-1:0] bases_q, bases_d;
  logic [LenW-1:0]        fill_q, fill_d;
  logic [CountWidth-1:0]  total_q, total_d;

  // Shift in the new base; a fragment start restarts window and count
  always_comb begin
    bases_d = bases_q;
    fill_d  = fill_q;
    total_d = total_q;
    if (item_i.accept) begin
      if (item_i.fragment_start) begin
        bases_d    = '0;
        bases_d[0] = item_i.base;
        fill_d     = LenW'(1);
        total_d    = CountWidth'(1);
      end else begin
        for (int i = MaxPattern - 1; i > 0; i--) begin
          bases_d[i] = bases_q[i-1];
        end
        bases_d[0] = item_i.base;
        if (fill_q < LenW'(MaxPattern)) begin
          fill_d = fill_q + LenW'(1);
        end
        if (total_q != {CountWidth{1'b1}}) begin
          total_d = total_q + CountWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_q <= '0;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      bases_q <= bases_d;
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  assign win_o.bases = bases_q;
  assign win_o.fill  = fill_q;
  assign win_o.total = total_q;

endmodule

`default_nettype wire

@@ sv/rss_match.sv @@
`default_nettype none

module rss_match import rss_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                load_i,
  input  wire scan_cfg_t           cfg_i,
  input  wire win_state_t          win_i,
  output logic                     plus_hit_o,
  output logic [PosWidth-1:0]      plus_pos_o,
  output logic                     minus_hit_o,
  output logic [PosWidth-1:0]      minus_pos_o
);

  localparam int unsigned CalcW = (CountWidth > PosWidth) ? CountWidth : PosWidth;

  logic              plus_ok, minus_ok, full, plus_hit, minus_hit;
  logic [CalcW-1:0]  total_x, ppos, mpos;

  // Parallel subset test over all slots
  always_comb begin
    plus_ok  = 1'b1;
    minus_ok = 1'b1;
    for (int j = 0; j < MaxPattern; j++) begin
      if (cfg_i.slot_en[j]) begin
        if ((win_i.bases[j] & ~cfg_i.plus_pat[j]) != 4'd0)  plus_ok  = 1'b0;
        if ((win_i.bases[j] & ~cfg_i.minus_pat[j]) != 4'd0) minus_ok = 1'b0;
      end
    end
    full      = (win_i.fill >= cfg_i.len);
    plus_hit  = full && plus_ok;
    minus_hit = full && ((plus_hit && cfg_i.palindrome) || minus_ok);
    total_x   = CalcW'(win_i.total);
    ppos      = total_x - CalcW'(cfg_i.len - cfg_i.nick);
    mpos      = total_x - CalcW'(cfg_i.nick);
  end

  // Result register; a strand without a hit reports position zero
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plus_hit_o  <= plus_hit;
      minus_hit_o <= minus_hit;
      plus_pos_o  <= plus_hit  ? PosWidth'(ppos) : '0;
      minus_pos_o <= minus_hit ? PosWidth'(mpos) : '0;
    end
  end

endmodule

`default_nettype wire

@@ sv/restriction_site_scanner_top.sv @@
// Restriction site scanner: takes one DNA base per transfer (4-bit ambiguity
// mask in s_axis_tdata, fragment start in s_axis_tuser) and returns exactly one
// result per base, telling whether the recognition pattern ends at that base
// on the plus strand and whether its reverse complement does on the minus
// strand, with the nick positions counted from the start of the fragment.
// Throughput is one base per cycle while the result side keeps up; each
// result passes the window register, then the result register. While a
// finished result waits the input takes one more base, then holds tready low
// until the result leaves. Configuration writes pass the register file and
// the set-up register and must only be made while no base is in flight.
`default_nettype none

module restriction_site_scanner_top import rss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // [3:0] base_mask, [7:4] zero
  input  wire logic [0:0]         s_axis_tuser,  // [0] fragment_start
  // result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [0] plus_hit, [32:1] plus_position, [33] minus_hit,
  // [65:34] minus_position, [71:66] zero
  output logic [71:0]             m_axis_tdata,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [PatWidth-1:0] cfg_data_i
);

  `include "restriction_site_scanner_top_assert.svh"

  scan_cfg_t          cfg;
  win_state_t         win;
  in_item_t           item;
  logic               mid_valid_q, mid_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               plus_hit, minus_hit;
  logic [PosWidth-1:0] plus_pos, minus_pos;

  assign cfg_ready_o = 1'b1;

  // Flow control: window stage feeds the result register
  assign out_load      = mid_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !mid_valid_q || out_load;

  assign item.accept         = s_axis_tvalid && s_axis_tready;
  assign item.base           = s_axis_tdata[3:0];
  assign item.fragment_start = s_axis_tuser[0];

  always_comb begin
    mid_valid_d = mid_valid_q;
    if (item.accept) begin
      mid_valid_d = 1'b1;
    end else if (out_load) begin
      mid_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  rss_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i && cfg_ready_o),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rss_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .win_o  (win)
  );

  rss_match u_match (
    .clk_i       (clk_i),
    .load_i      (out_load),
    .cfg_i       (cfg),
    .win_i       (win),
    .plus_hit_o  (plus_hit),
    .plus_pos_o  (plus_pos),
    .minus_hit_o (minus_hit),
    .minus_pos_o (minus_pos)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, minus_pos, minus_hit, plus_pos, plus_hit};

  // Checks
  `RSS_ASSERT(a_mid_holds, mid_valid_q && !out_load |=> mid_valid_q, "window result lost")
  `RSS_ASSERT(a_stall_cause, !s_axis_tready |-> (mid_valid_q && out_valid_q && !m_axis_tready), "input stalled without a full pipeline")
  `RSS_ASSERT(a_plus_pos_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '0, "plus position without plus hit")
  `RSS_ASSERT(a_minus_pos_zero, m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[65:34] == '0, "minus position without minus hit")
  `RSS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
  import rss_pkg::*;

  localparam base_t BaseA = 4'h1;
  localparam base_t BaseC = 4'h2;
  localparam base_t BaseG = 4'h4;
  localparam base_t BaseT = 4'h8;

  localparam int NPhases      = 6;
  localparam int PhaseItems   = 250;
  localparam int SettleCycles = 4;
  localparam int LimitCycles  = 400_000;

  // One result transfer, split into its fields
  typedef struct packed {
    logic        plus_hit;
    logic [31:0] plus_pos;
    logic        minus_hit;
    logic [31:0] minus_pos;
  } hit_rec_t;

  typedef enum logic {RowBase, RowCfg} row_kind_e;

  // Directed step: either a base transfer or a register write
  typedef struct packed {
    row_kind_e     kind;
    cfg_idx_e      idx;
    logic [63:0]   val;
    base_t         mask;
    logic          frag;
    logic          typed;
    hit_rec_t      want;
  } plan_row_t;

  localparam hit_rec_t NoHit = '0;
  localparam int NPlan = 30;

  localparam plan_row_t Plan [NPlan] = '{
    // reset set-up: pattern is a single all-zero base, so only a zero mask matches
    '{RowBase, CfgPatternBases, 64'h0, 4'h0,  1'b1, 1'b1, '{1'b1, 32'd0, 1'b1, 32'd1}},
    '{RowBase, CfgPatternBases, 64'h0, 4'hF,  1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseA, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, 4'h0,  1'b0, 1'b1, '{1'b1, 32'd3, 1'b1, 32'd4}},
    // GAATTC, nick after the first base, palindromic
    '{RowCfg, CfgPatternBases,  64'h288114, 4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgPatternLength, 64'd6,      4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgNickOffset,    64'd1,      4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgPalindrome,    64'd1,      4'h0, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseG, 1'b1, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseA, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseA, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseT, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseT, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseC, 1'b0, 1'b1, '{1'b1, 32'd1, 1'b1, 32'd5}},
    '{RowBase, CfgPatternBases, 64'h0, BaseG, 1'b0, 1'b0, NoHit},
    // GAC, not palindromic: plus then minus (GTC) site
    '{RowCfg, CfgPatternBases,  64'h214, 4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgPatternLength, 64'd3,   4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgNickOffset,    64'd0,   4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgPalindrome,    64'd0,   4'h0, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseG, 1'b1, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseA, 1'b0, 1'b1, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseC, 1'b0, 1'b1, '{1'b1, 32'd0, 1'b0, 32'd0}},
    '{RowBase, CfgPatternBases, 64'h0, BaseG, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseT, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseC, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b1, 32'd6}},
    // length zero counts as one, nick beyond the pattern is clamped
    '{RowCfg, CfgPatternLength, 64'd0,  4'h0, 1'b0, 1'b0, NoHit},
    '{RowCfg, CfgNickOffset,    64'd31, 4'h0, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseG, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, BaseC, 1'b0, 1'b0, NoHit},
    '{RowBase, CfgPatternBases, 64'h0, 4'h0,  1'b0, 1'b0, NoHit}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [71:0]         m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [PatWidth-1:0] cfg_data_i = '0;

  // Shadow of the register file and the scan window
  logic [PatWidth-1:0]   pat_cfg = '0;
  logic [4:0]            len_cfg = 5'd1;
  logic [4:0]            nick_cfg = '0;
  logic                  pal_cfg = 1'b0;
  base_t                 seen [MaxPattern] = '{default: '0};
  logic [4:0]            seen_fill = '0;
  logic [CountWidth-1:0] frag_count = '0;

  hit_rec_t    pending_hits [$];
  int unsigned fails = 0;
  bit          calm = 1'b0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  int          stall_left = 0;

  restriction_site_scanner_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Effective pattern length after clamping
  function automatic int unsigned pattern_span();
    if (len_cfg == 0) return 1;
    if (len_cfg > MaxPattern) return MaxPattern;
    return 32'(len_cfg);
  endfunction

  function automatic base_t pat_nib(int unsigned i);
    return pat_cfg[4*i +: 4];
  endfunction

  // Complementary base: bit order reversed
  function automatic base_t flip_mask(base_t m);
    return {m[0], m[1], m[2], m[3]};
  endfunction

  // Subset test over the newest n bases; rev selects the reverse complement
  function automatic logic strand_hit(int unsigned n, logic rev);
    base_t r;
    base_t q;
    for (int unsigned i = 0; i < n; i++) begin
      r = seen[n-1-i];
      q = rev ? flip_mask(pat_nib(n-1-i)) : pat_nib(i);
      if ((r & q) != r) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Shift one base into the shadow window and work out the site result
  function automatic hit_rec_t scan_base(base_t b, logic frag);
    hit_rec_t    res;
    int unsigned n;
    int unsigned nk;
    res = NoHit;
    if (frag) begin
      foreach (seen[i]) seen[i] = '0;
      seen_fill = '0;
      frag_count = '0;
    end
    for (int i = MaxPattern - 1; i > 0; i--) seen[i] = seen[i-1];
    seen[0] = b;
    if (seen_fill < MaxPattern) seen_fill++;
    if (frag_count != '1) frag_count++;
    n = pattern_span();
    nk = (32'(nick_cfg) > n) ? n : 32'(nick_cfg);
    if (seen_fill >= n) begin
      res.plus_hit = strand_hit(n, 1'b0);
      res.minus_hit = (res.plus_hit && pal_cfg) ? 1'b1 : strand_hit(n, 1'b1);
      if (res.plus_hit) res.plus_pos = frag_count - (n - nk);
      if (res.minus_hit) res.minus_pos = frag_count - nk;
    end
    return res;
  endfunction

  // A random base that fits inside the given pattern base
  function automatic base_t instance_of(base_t p);
    base_t s;
    s = p & base_t'($urandom_range(0, 15));
    return (s == 0) ? p : s;
  endfunction

  // Offer one base, wait for the transfer, then queue its expected result
  task automatic feed_base(base_t mask, logic frag, logic typed, hit_rec_t want);
    hit_rec_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, mask};
    s_axis_tuser  <= frag;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = scan_base(mask, frag);
    pending_hits.push_back(typed ? want : pred);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Register write; valid is left high so writes can follow back to back
  task automatic put_reg(cfg_idx_e idx, logic [PatWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgPatternBases:  pat_cfg = val;
      CfgPatternLength: len_cfg = val[4:0];
      CfgNickOffset:    nick_cfg = val[4:0];
      CfgPalindrome:    pal_cfg = val[0];
      default: ;
    endcase
  endtask

  // Stop offering bases and let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expected one
  always @(posedge clk_i) begin : check_hits
    hit_rec_t want;
    hit_rec_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[33], m_axis_tdata[65:34]};
      if (pending_hits.size() == 0) begin
        $error("result transfer with no site result pending");
        fails++;
      end else begin
        want = pending_hits.pop_front();
        if (got.plus_hit !== want.plus_hit) begin
          $error("plus_hit: expected %0d, got %0d", want.plus_hit, got.plus_hit);
          fails++;
        end
        if (got.plus_pos !== want.plus_pos) begin
          $error("plus_position: expected %0d, got %0d", want.plus_pos, got.plus_pos);
          fails++;
        end
        if (got.minus_hit !== want.minus_hit) begin
          $error("minus_hit: expected %0d, got %0d", want.minus_hit, got.minus_hit);
          fails++;
        end
        if (got.minus_pos !== want.minus_pos) begin
          $error("minus_position: expected %0d, got %0d", want.minus_pos, got.minus_pos);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    base_t               motif [$];
    logic [PatWidth-1:0] pat;
    logic [4:0]          len_w;
    logic [4:0]          nick_w;
    logic                pal_w;
    logic                frag;
    int unsigned         n;
    int unsigned         pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; consecutive register rows share one write burst
    for (int k = 0; k < NPlan; k++) begin
      if (Plan[k].kind == RowCfg) begin
        if (k == 0 || Plan[k-1].kind != RowCfg) settle();
        put_reg(Plan[k].idx, Plan[k].val);
        if (k == NPlan - 1 || Plan[k+1].kind != RowCfg) cfg_valid_i <= 1'b0;
      end else begin
        feed_base(Plan[k].mask, Plan[k].frag, Plan[k].typed, Plan[k].want);
      end
    end

    // Random phases, each with its own set-up and idling mix
    for (int p = 0; p < NPhases; p++) begin
      settle();
      case (p)
        0: begin
          pat = '1; len_w = 5'd16; nick_w = 5'd16; pal_w = 1'b0;
        end
        1: begin
          pat = {$urandom, $urandom}; len_w = 5'd31; nick_w = 5'd31; pal_w = 1'b1;
        end
        default: begin
          for (int i = 0; i < PatNibbles; i++) pat[4*i +: 4] = base_t'($urandom_range(1, 15));
          if (p == 2) len_w = 5'd1;
          else if ($urandom_range(0, 2) == 0) len_w = 5'($urandom_range(0, 31));
          else len_w = 5'($urandom_range(2, 8));
          nick_w = (p == 2) ? 5'd0 : 5'($urandom_range(0, 16));
          pal_w = 1'($urandom_range(0, 1));
        end
      endcase
      put_reg(CfgPatternBases, pat);
      put_reg(CfgPatternLength, PatWidth'(len_w));
      put_reg(CfgNickOffset, PatWidth'(nick_w));
      put_reg(CfgPalindrome, PatWidth'(pal_w));
      cfg_valid_i <= 1'b0;
      calm = (p == NPhases - 1);
      gap_pct = calm ? 0 : 10 * $urandom_range(0, 3);
      stall_pct = calm ? 0 : 10 * $urandom_range(0, 3);
      n = pattern_span();
      motif.delete();

      // Mostly planted sites on either strand, some mutated, the rest noise
      for (int j = 0; j < PhaseItems; j++) begin
        if (motif.size() == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            for (int i = 0; i < n; i++) motif.push_back(instance_of(pat_nib(i)));
          end else if (pick < 70) begin
            for (int i = 0; i < n; i++) motif.push_back(flip_mask(instance_of(pat_nib(n-1-i))));
          end else begin
            motif.push_back(($urandom_range(0, 49) == 0) ? 4'h0 : base_t'($urandom_range(1, 15)));
          end
          if (pick < 70 && $urandom_range(0, 9) == 0)
            motif[$urandom_range(0, motif.size() - 1)] = base_t'($urandom_range(0, 15));
        end
        frag = ($urandom_range(0, 59) == 0);
        feed_base(motif.pop_front(), frag, 1'b0, NoHit);
      end
    end

    settle();
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * LimitCycles);
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/rss_pkg.sv
sv/rss_cfg.sv
sv/rss_window.sv
sv/rss_match.sv
sv/restriction_site_scanner_top.sv
bench/tb_top.sv
